>>> design/escape_rle_row_pad_decoder_assert.svh
// Assertion macros used by the decoder datapath.
`ifndef ESCAPE_RLE_ROW_PAD_DECODER_ASSERT_SVH
`define ESCAPE_RLE_ROW_PAD_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Plain property that must hold at every enabled edge.
`define ERLE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("erle assertion failed");

// Same-cycle implication.
`define ERLE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("erle assertion failed");

// Next-cycle implication.
`define ERLE_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("erle assertion failed");

`else

`define ERLE_ASSERT(name, clk, rst, prop)
`define ERLE_ASSERT_IMP(name, clk, rst, ante, cons)
`define ERLE_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

>>> design/erle_pkg.sv
`timescale 1ns / 1ps

package erle_pkg;

  localparam int WORD_BYTES_DEF = 8;
  localparam int PACKED_W       = 64;
  localparam int COUNT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int ROW_W          = 18;
  localparam int RUN_W          = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE  = 2'd2;

  localparam logic [15:0] RESET_IMAGE_WIDTH = 16'd1;
  localparam logic [7:0]  RESET_ESCAPE_CODE = 8'd128;

  typedef enum logic [1:0] {
    PH_NORM = 2'd0,
    PH_ESC  = 2'd1,
    PH_CNT  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_HOLD = 2'd1,
    EMIT_PART = 2'd2
  } emit_t;

  typedef struct packed {
    logic  latch;
    logic  decode;
    logic  push;
    emit_t emit;
    logic  emit_end;
    logic  clear;
  } erle_cmd_t;

  typedef struct packed {
    logic hold_valid;
    logic fill_zero;
    logic out_free;
    logic push_blocked;
    logic run_none;
    logic run_last;
    logic fin;
  } erle_stat_t;

endpackage

>>> design/erle_if.sv
`timescale 1ns / 1ps

interface erle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;

  modport source (output valid, output code_byte, output final_byte, input ready);
  modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface erle_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] packed_bytes;
  logic [3:0]  byte_count;
  logic        stream_end;
  logic        truncated;

  modport source (output valid, output packed_bytes, output byte_count,
                  output stream_end, output truncated, input ready);
  modport sink   (input valid, input packed_bytes, input byte_count,
                  input stream_end, input truncated, output ready);
endinterface

>>> design/erle_ctrl.sv
`timescale 1ns / 1ps

module erle_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  erle_pkg::erle_stat_t stat,
  output erle_pkg::erle_cmd_t  cmd
);
  import erle_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_RUN    = 5'b00100,
    S_FINISH = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.emit     = EMIT_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (stat.run_none) begin
          state_next = S_FINISH;
        end else if (!stat.push_blocked) begin
          cmd.push = 1'b1;
          if (stat.run_last) begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (!stat.fin) begin
          // The held word is not the last of the image: release it.
          if (!stat.hold_valid) begin
            state_next = S_IDLE;
          end else if (stat.out_free) begin
            cmd.emit   = EMIT_HOLD;
            state_next = S_IDLE;
          end
        end else if (stat.out_free) begin
          if (stat.hold_valid && stat.fill_zero) begin
            cmd.emit     = EMIT_HOLD;
            cmd.emit_end = 1'b1;
            cmd.clear    = 1'b1;
            state_next   = S_IDLE;
          end else if (stat.hold_valid) begin
            cmd.emit   = EMIT_HOLD;
            state_next = S_FLUSH;
          end else begin
            cmd.emit     = EMIT_PART;
            cmd.emit_end = 1'b1;
            cmd.clear    = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.emit     = EMIT_PART;
          cmd.emit_end = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/erle_dp.sv
`timescale 1ns / 1ps
`include "escape_rle_row_pad_decoder_assert.svh"

module erle_dp #(
  parameter int WORD_BYTES = erle_pkg::WORD_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [erle_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [erle_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [7:0]                           in_code_byte,
  input  logic                                 in_final_byte,
  input  erle_pkg::erle_cmd_t                  cmd,
  output erle_pkg::erle_stat_t                 stat,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [erle_pkg::PACKED_W-1:0]        out_packed_bytes,
  output logic [erle_pkg::COUNT_W-1:0]         out_byte_count,
  output logic                                 out_stream_end,
  output logic                                 out_truncated
);
  import erle_pkg::*;

  localparam int PACK_W = 8 * WORD_BYTES;
  localparam int FILL_W = $clog2(WORD_BYTES + 1);

  // Configuration registers.
  logic [15:0] image_width;
  logic        direct_color;
  logic [7:0]  escape_code;

  // Decode state.
  logic [7:0]        byte_q;
  logic              fin_q;
  phase_t            phase;
  logic [7:0]        pend;
  logic [RUN_W-1:0]  run_left;
  logic [7:0]        push_val;
  logic [ROW_W-1:0]  row_pos;
  logic [PACK_W-1:0] pack;
  logic [FILL_W-1:0] fill;
  logic [PACK_W-1:0] hold;
  logic              hold_valid;

  logic [ROW_W-1:0]  width_ext;
  logic [ROW_W-1:0]  row_len;
  logic              kept;
  logic [ROW_W-1:0]  row_pos_next;
  logic              word_done;
  logic [PACK_W-1:0] pack_ins;
  logic              out_free;
  logic              out_load;

  always_comb begin
    width_ext = (image_width == '0) ? ROW_W'(1) : ROW_W'(image_width);
    row_len   = direct_color ? ((width_ext << 1) + width_ext) : width_ext;
    if (row_len[0]) begin
      // Odd rows end with a pad byte that is dropped.
      kept         = (row_pos < row_len);
      row_pos_next = kept ? (row_pos + ROW_W'(1)) : '0;
    end else begin
      kept         = 1'b1;
      row_pos_next = (row_pos >= row_len - ROW_W'(1)) ? '0 : (row_pos + ROW_W'(1));
    end
  end

  assign word_done = kept && (fill == FILL_W'(WORD_BYTES - 1));
  assign pack_ins  = pack | (PACK_W'(push_val) << {fill, 3'b000});
  assign out_free  = !out_valid || out_ready;
  assign out_load  = (cmd.push && word_done && hold_valid) || (cmd.emit != EMIT_NONE);

  always_comb begin
    stat.hold_valid   = hold_valid;
    stat.fill_zero    = (fill == '0);
    stat.out_free     = out_free;
    stat.push_blocked = word_done && hold_valid && !out_free;
    stat.run_none     = (run_left == '0);
    stat.run_last     = (run_left == RUN_W'(1));
    stat.fin          = fin_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      direct_color <= 1'b0;
      escape_code  <= RESET_ESCAPE_CODE;
      phase        <= PH_NORM;
      pend         <= '0;
      run_left     <= '0;
      row_pos      <= '0;
      pack         <= '0;
      fill         <= '0;
      hold_valid   <= 1'b0;
      out_valid    <= 1'b0;
      fin_q        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
          CFG_DIRECT_COLOR: direct_color <= cfg_data[0];
          CFG_ESCAPE_CODE:  escape_code  <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.latch) begin
        byte_q <= in_code_byte;
        fin_q  <= in_final_byte;
      end

      if (cmd.decode) begin
        case (phase)
          PH_ESC: begin
            if (byte_q == '0) begin
              push_val <= escape_code;
              run_left <= RUN_W'(1);
              phase    <= PH_NORM;
            end else begin
              pend     <= byte_q;
              run_left <= '0;
              phase    <= PH_CNT;
            end
          end
          PH_CNT: begin
            push_val <= byte_q;
            run_left <= RUN_W'(pend) + RUN_W'(1);
            pend     <= '0;
            phase    <= PH_NORM;
          end
          default: begin
            push_val <= byte_q;
            if (byte_q == escape_code) begin
              run_left <= '0;
              phase    <= PH_ESC;
            end else begin
              run_left <= RUN_W'(1);
              phase    <= PH_NORM;
            end
          end
        endcase
      end

      if (cmd.push) begin
        run_left <= run_left - RUN_W'(1);
        row_pos  <= row_pos_next;
        if (kept) begin
          if (word_done) begin
            pack <= '0;
            fill <= '0;
            hold <= pack_ins;
            hold_valid <= 1'b1;
            if (hold_valid) begin
              out_packed_bytes <= PACKED_W'(hold);
              out_byte_count   <= COUNT_W'(WORD_BYTES);
              out_stream_end   <= 1'b0;
              out_truncated    <= 1'b0;
            end
          end else begin
            pack <= pack_ins;
            fill <= fill + FILL_W'(1);
          end
        end
      end

      case (cmd.emit)
        EMIT_HOLD: begin
          out_packed_bytes <= PACKED_W'(hold);
          out_byte_count   <= COUNT_W'(WORD_BYTES);
          out_stream_end   <= cmd.emit_end;
          out_truncated    <= cmd.emit_end && (phase != PH_NORM);
          hold_valid       <= 1'b0;
        end
        EMIT_PART: begin
          out_packed_bytes <= PACKED_W'(pack);
          out_byte_count   <= COUNT_W'(fill);
          out_stream_end   <= cmd.emit_end;
          out_truncated    <= cmd.emit_end && (phase != PH_NORM);
        end
        default: ;
      endcase

      if (cmd.clear) begin
        phase   <= PH_NORM;
        pend    <= '0;
        row_pos <= '0;
        pack    <= '0;
        fill    <= '0;
      end
    end
  end

  `ERLE_ASSERT(a_fill_range, clk, rst, fill < FILL_W'(WORD_BYTES))
  `ERLE_ASSERT_IMP(a_emit_room, clk, rst, cmd.emit != EMIT_NONE, out_free)
  `ERLE_ASSERT_IMP(a_push_has_run, clk, rst, cmd.push, run_left != '0)
  `ERLE_ASSERT_NXT(a_word_held, clk, rst, cmd.push && word_done, hold_valid)

endmodule

>>> design/escape_rle_row_pad_decoder.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                                            Beat when
// in_ch     sink       code_byte[7:0], final_byte                         valid & ready
// out_ch    source     packed_bytes[63:0], byte_count[3:0], stream_end,   valid & ready
//                      truncated
// cfg       write      cfg_we, cfg_index[1:0], cfg_data[15:0]             cfg_we
//
// An input byte passes through an accept state, a decode state, a run state that places
// the decoded bytes it produces (count+1 bytes for a run, none for an escape or count
// byte) and a finishing state; a new byte is accepted only once the block is idle again.
// The packing datapath places one decoded byte per cycle unless the run stalls.
// The final byte of an image also passes through a flush state when both a full and
// a partial word are left to send. Reset is synchronous and clears the decode state
// and restores the configuration registers to their defaults. A stalled output stalls
// the run when a second word completes while the previous one cannot move out, and it
// holds the finishing and flush states while a word waits for the output register.
module escape_rle_row_pad_decoder #(
  parameter int WORD_BYTES = erle_pkg::WORD_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  erle_in_if.sink                         in_ch,
  erle_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [erle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erle_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erle_pkg::*;

  erle_cmd_t  cmd;
  erle_stat_t stat;

  // The controller sequences each input beat: decode, byte-by-byte packing, and
  // the closing step that decides which word carries the end-of-image flag.
  erle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, escape state, row position, the word
  // being packed, one completed word held back, and the output register. Holding
  // one full word back lets the last word of an image take the end flag when no
  // partial word follows it.
  erle_dp #(
    .WORD_BYTES (WORD_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_code_byte     (in_ch.code_byte),
    .in_final_byte    (in_ch.final_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_packed_bytes (out_ch.packed_bytes),
    .out_byte_count   (out_ch.byte_count),
    .out_stream_end   (out_ch.stream_end),
    .out_truncated    (out_ch.truncated)
  );

endmodule

>>> tb/sv/escape_rle_row_pad_decoder_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the escape-coded run-length decoder with row-pad removal.
// Compressed bytes go in on in_ch, packed words come out on out_ch, and every output
// beat is compared field by field against a software decoder that runs in step with
// the input handshake.
module escape_rle_row_pad_decoder_tb;
  import erle_pkg::*;

  // Bytes per output word, taken from the package default that the block uses.
  localparam int WB = WORD_BYTES_DEF;

  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // A run of 256 bytes is placed one byte per cycle unless the run stalls on the output,
  // so this many quiet cycles are enough for any byte still in flight to settle.
  localparam int SETTLE_CYCLES = 300;

  // Worst case is far below this: a few hundred beats, each at most a 256-byte run
  // whose words each wait out a long receiver stall, plus the back-pressure stretch.
  localparam int LIMIT_CYCLES = 1_500_000;

  localparam int DIRECTED_ROWS = 24;
  localparam int PHASE_BEATS   = 64;
  localparam int HOLD_CYCLES   = 500;

  // Mismatch lines stop after this many so a broken block cannot flood the log.
  localparam int MAX_REPORTS = 40;

  // One output word as the block presents it.
  typedef struct packed {
    logic [63:0] word_bytes;
    logic [3:0]  nbytes;
    logic        image_end;
    logic        cut_short;
  } decoded_word_t;

  // One row of the directed table. A row may first reprogram the registers, and a
  // row that closes an image with an obvious result carries that result typed in.
  typedef struct packed {
    logic          recfg;
    logic [15:0]   width;
    logic          color;
    logic [7:0]    esc;
    logic [7:0]    code;
    logic          fin;
    logic          typed;
    decoded_word_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  erle_in_if  in_ch ();
  erle_out_if out_ch ();

  escape_rle_row_pad_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Software decoder. It keeps its own copy of the registers and of the decode
  // state, and it advances exactly once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [15:0] width_reg = RESET_IMAGE_WIDTH;
  logic        color_reg = 1'b0;
  logic [7:0]  esc_reg   = RESET_ESCAPE_CODE;

  phase_t      dec_phase = PH_NORM;
  logic [7:0]  run_count = '0;
  int unsigned row_pos   = 0;
  logic [63:0] pack_buf  = '0;
  int unsigned pack_fill = 0;

  decoded_word_t step_words[$];      // words produced by the current beat
  decoded_word_t expected_words[$];  // words the block still owes, oldest first

  int beats_sent    = 0;
  int images_seen   = 0;
  int truncations   = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  stim_row_t dir_rows [DIRECTED_ROWS];

  // Places one decoded byte. The row position decides whether the byte is the pad
  // that closes a row of odd length; a position already past the row end, which
  // only happens after the row length shrinks mid-image, counts as the end of the row.
  function automatic void place_byte(input logic [7:0] b);
    int unsigned w_eff;
    int unsigned row_len;
    w_eff   = (width_reg == 16'd0) ? 1 : width_reg;
    row_len = color_reg ? 3 * w_eff : w_eff;
    if (row_len % 2 == 1) begin
      if (row_pos >= row_len) begin
        row_pos = 0;
        return;
      end
      row_pos++;
    end else begin
      if (row_pos >= row_len - 1)
        row_pos = 0;
      else
        row_pos++;
    end
    pack_buf[8*pack_fill +: 8] = b;
    pack_fill++;
    if (pack_fill >= WB) begin
      step_words.push_back(decoded_word_t'{pack_buf, 4'(pack_fill), 1'b0, 1'b0});
      pack_buf  = '0;
      pack_fill = 0;
    end
  endfunction

  // Decodes one accepted beat and queues the words it causes. A typed row supplies
  // its own expectation in place of the computed one, but the state still advances.
  function automatic void decode_beat(input logic [7:0] code, input logic fin,
                                      input logic typed, input decoded_word_t want);
    logic cut;
    int   k;
    step_words.delete();
    case (dec_phase)
      PH_ESC: begin
        if (code == 8'd0) begin
          place_byte(esc_reg);
          dec_phase = PH_NORM;
        end else begin
          run_count = code;
          dec_phase = PH_CNT;
        end
      end
      PH_CNT: begin
        for (k = 0; k <= run_count; k++)
          place_byte(code);
        run_count = '0;
        dec_phase = PH_NORM;
      end
      default: begin
        dec_phase = PH_NORM;
        if (code == esc_reg)
          dec_phase = PH_ESC;
        else
          place_byte(code);
      end
    endcase

    // Closing an image: a partial word goes out with the end mark; otherwise the
    // last word of this beat takes it; otherwise an empty word carries it alone.
    if (fin) begin
      cut = (dec_phase != PH_NORM);
      images_seen++;
      if (cut)
        truncations++;
      if (pack_fill > 0) begin
        step_words.push_back(decoded_word_t'{pack_buf, 4'(pack_fill), 1'b1, cut});
      end else if (step_words.size() > 0) begin
        step_words[step_words.size()-1].image_end = 1'b1;
        step_words[step_words.size()-1].cut_short = cut;
      end else begin
        step_words.push_back(decoded_word_t'{64'd0, 4'd0, 1'b1, cut});
      end
      dec_phase = PH_NORM;
      run_count = '0;
      row_pos   = 0;
      pack_buf  = '0;
      pack_fill = 0;
    end

    if (typed)
      expected_words.push_back(want);
    else
      foreach (step_words[i])
        expected_words.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers.
  // ---------------------------------------------------------------------------
  function automatic stim_row_t lit_row(input logic [7:0] code, input logic fin);
    stim_row_t r;
    r      = '0;
    r.code = code;
    r.fin  = fin;
    return r;
  endfunction

  // A row that closes an image whose single word is obvious by inspection.
  function automatic stim_row_t typed_row(input logic [7:0] code, input logic fin,
                                          input logic [63:0] data, input logic [3:0] cnt,
                                          input logic cut);
    stim_row_t r;
    r       = lit_row(code, fin);
    r.typed = 1'b1;
    r.want  = decoded_word_t'{data, cnt, 1'b1, cut};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [15:0] width, input logic color,
                                        input logic [7:0] esc, input logic [7:0] code,
                                        input logic fin);
    stim_row_t r;
    r       = lit_row(code, fin);
    r.recfg = 1'b1;
    r.width = width;
    r.color = color;
    r.esc   = esc;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the output checker.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Every output beat is matched against the oldest outstanding word. Values are
  // sampled at the edge, before the block's own updates land, so ordering within
  // the time step does not matter.
  always @(posedge clk) begin : word_check
    decoded_word_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing outstanding", out_ch.packed_bytes, '0);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.packed_bytes !== want.word_bytes)
          report_mismatch("packed_bytes", out_ch.packed_bytes, want.word_bytes);
        if (out_ch.byte_count !== want.nbytes)
          report_mismatch("byte_count", out_ch.byte_count, want.nbytes);
        if (out_ch.stream_end !== want.image_end)
          report_mismatch("stream_end", out_ch.stream_end, want.image_end);
        if (out_ch.truncated !== want.cut_short)
          report_mismatch("truncated", out_ch.truncated, want.cut_short);
      end
    end
  end

  // Receiver. A pending hold-off keeps ready low for a counted stretch; otherwise
  // ready drops at random with the current stall rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a hung block or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, expected_words.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks.
  // ---------------------------------------------------------------------------

  // Offers one input beat, waits for the handshake, advances the software decoder,
  // then idles the sender at random. valid stays high when the next beat follows
  // at once, so it is never lowered and raised in the same step.
  task automatic send_beat(input logic [7:0] code, input logic fin, input logic typed,
                           input decoded_word_t want);
    in_ch.valid      <= 1'b1;
    in_ch.code_byte  <= code;
    in_ch.final_byte <= fin;
    do
      @(posedge clk);
    while (!(in_ch.valid && in_ch.ready));
    decode_beat(code, fin, typed, want);
    beats_sent++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stops sending and waits until every outstanding word has arrived, then lets the
  // block finish any bytes that produce no word before the registers may change.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers, then the unused index. The spare upper data bits
  // are random on the narrow registers, since only the low bits may count.
  task automatic configure(input logic [15:0] width, input logic color,
                           input logic [7:0] esc);
    logic [CFG_DATA_W-1:0] d;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    width_reg = width;
    d         = CFG_DATA_W'($urandom);
    d[0]      = color;
    cfg_index <= CFG_DIRECT_COLOR;
    cfg_data  <= d;
    @(posedge clk);
    color_reg = color;
    d         = CFG_DATA_W'($urandom);
    d[7:0]    = esc;
    cfg_index <= CFG_ESCAPE_CODE;
    cfg_data  <= d;
    @(posedge clk);
    esc_reg   = esc;
    cfg_index <= CFG_UNUSED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sends one well-formed token of compressed data, or now and then a stray byte or
  // a broken ending. The token's last beat carries the image end when asked.
  task automatic send_token(input logic last);
    int         roll;
    logic [7:0] b;
    logic [7:0] cnt;
    roll = $urandom_range(99);
    if (roll < 45) begin
      // Plain literal.
      do
        b = 8'($urandom);
      while (b == esc_reg);
      send_beat(b, last, 1'b0, '0);
    end else if (roll < 55) begin
      // Escape followed by zero: a literal escape byte.
      send_beat(esc_reg, 1'b0, 1'b0, '0);
      send_beat(8'd0, last, 1'b0, '0);
    end else if (roll < 85) begin
      // Run. Long runs are kept rare since each places from 129 to 256 bytes.
      if ($urandom_range(99) < 4)
        cnt = 8'($urandom_range(255, 128));
      else
        cnt = 8'($urandom_range(15, 1));
      send_beat(esc_reg, 1'b0, 1'b0, '0);
      send_beat(cnt, 1'b0, 1'b0, '0);
      send_beat(8'($urandom), last, 1'b0, '0);
    end else if (roll < 93 || !last) begin
      // Stray byte; may well be an escape that reshapes what follows.
      send_beat(8'($urandom), last, 1'b0, '0);
    end else if ($urandom_range(1) == 1) begin
      // Image ends right after an escape.
      send_beat(esc_reg, 1'b1, 1'b0, '0);
    end else begin
      // Image ends right after a run count.
      send_beat(esc_reg, 1'b0, 1'b0, '0);
      send_beat(8'($urandom_range(255, 1)), 1'b1, 1'b0, '0);
    end
  endtask

  // One random phase: new register settings, new idle rates, then images of random
  // length until enough beats have gone in. The last image is usually left open, so
  // the next phase reprograms the registers in the middle of an image.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int hold,
                           input logic [15:0] width, input logic color,
                           input logic [7:0] esc);
    int start;
    int t;
    drain();
    configure(width, color, esc);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    hold_left      = hold;
    start          = beats_sent;
    while (beats_sent - start < PHASE_BEATS) begin
      for (t = $urandom_range(24, 1); t > 0 && beats_sent - start < PHASE_BEATS; t--)
        send_token(t == 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    in_ch.valid      <= 1'b0;
    in_ch.code_byte  <= '0;
    in_ch.final_byte <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_IMAGE_WIDTH;
    cfg_data         <= '0;

    // The first rows run on the reset settings: width 1, so every row has odd
    // length and every second decoded byte is the pad, and escape code 0x80.
    dir_rows = '{
      // Extremes of a lone literal, each closing its own image.
      typed_row(8'h00, 1'b1, 64'h00, 4'd1, 1'b0),
      typed_row(8'hFF, 1'b1, 64'hFF, 4'd1, 1'b0),
      // Image cut short after an escape, then after an escape and a count.
      typed_row(8'h80, 1'b1, 64'h00, 4'd0, 1'b1),
      lit_row(8'h80, 1'b0),
      typed_row(8'h05, 1'b1, 64'h00, 4'd0, 1'b1),
      // Escape then zero is a literal escape byte.
      lit_row(8'h80, 1'b0),
      typed_row(8'h00, 1'b1, 64'h80, 4'd1, 1'b0),
      // Three literals on width 1: the middle one is the row pad and is dropped.
      lit_row(8'h11, 1'b0),
      lit_row(8'h22, 1'b0),
      lit_row(8'h33, 1'b1),
      // Even row length: a run of eight fills exactly one word, which then takes
      // the end mark itself since nothing is left to flush.
      cfg_row(16'd4, 1'b0, 8'h80, 8'h80, 1'b0),
      lit_row(8'h07, 1'b0),
      typed_row(8'h3C, 1'b1, 64'h3C3C3C3C3C3C3C3C, 4'd8, 1'b0),
      // Zero width in direct color acts as a three-byte row; escape code 0xFF.
      // The longest run, then a literal escape, then a closing literal.
      cfg_row(16'd0, 1'b1, 8'hFF, 8'hFF, 1'b0),
      lit_row(8'hFF, 1'b0),
      lit_row(8'h00, 1'b0),
      lit_row(8'hFF, 1'b0),
      lit_row(8'h00, 1'b0),
      lit_row(8'h42, 1'b1),
      // Widest row with escape code zero; a run leaves the row position at ten.
      cfg_row(16'hFFFF, 1'b0, 8'h00, 8'h00, 1'b0),
      lit_row(8'h09, 1'b0),
      lit_row(8'h99, 1'b0),
      // The width then shrinks to an odd three mid-image: the row position is past
      // the end, so the next byte is dropped as pad and the row restarts.
      cfg_row(16'd3, 1'b0, 8'h00, 8'h7E, 1'b0),
      lit_row(8'h6D, 1'b1)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      if (dir_rows[r].recfg) begin
        drain();
        configure(dir_rows[r].width, dir_rows[r].color, dir_rows[r].esc);
      end
      send_beat(dir_rows[r].code, dir_rows[r].fin, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases, each with its own settings and idle pattern. The last one
    // holds the receiver off for a long stretch while beats keep coming, so the
    // block backs up and stalls its input.
    run_phase(0, 0, 0, 16'd3, 1'b0, 8'($urandom));
    run_phase(84, 0, 0, 16'($urandom_range(8, 1)), 1'b1, 8'h00);
    run_phase(0, 84, 0, 16'hFFFF, 1'b1, 8'hFF);
    run_phase(23, 23, 0, 16'd0, 1'b0, 8'($urandom));
    run_phase(0, 0, HOLD_CYCLES, 16'($urandom_range(20, 2)), 1'($urandom), RESET_ESCAPE_CODE);

    drain();

    $display("Decoded %0d input beats over %0d images (%0d cut short); %0d words checked.",
             beats_sent, images_seen, truncations, words_checked);
    $display("Settings spanned widths 0, 1 and 65535, both color modes, escape codes 0, 128 and 255, under idle, stall and back-pressure phases.");
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/erle_pkg.sv
design/erle_if.sv
design/erle_ctrl.sv
design/erle_dp.sv
design/escape_rle_row_pad_decoder.sv
tb/sv/escape_rle_row_pad_decoder_tb.sv
